/* design/tcbf_pkg.sv */
// Shared constants and helpers for the tape code block framer.
// Holds the fixed header bytes, result positions and config register indexes.
// No dependencies.
`default_nettype none

package tcbf_pkg;

  localparam int unsigned IdxW = 5;
  localparam int unsigned CfgIdxW = 1;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CFG_CODE_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LOAD_ADDR = 1'b1;

  localparam logic [15:0] LOAD_ADDR_RST = 16'h8000;

  localparam logic [7:0] BLOCK_ID     = 8'h10;
  localparam logic [7:0] PAUSE_LO     = 8'hE8;
  localparam logic [7:0] PAUSE_HI     = 8'h03;
  localparam logic [7:0] HDR_LEN_LO   = 8'h13;
  localparam logic [7:0] HDR_TYPE     = 8'h03;
  localparam logic [7:0] HDR_PARAM_HI = 8'h80;
  localparam logic [7:0] FLAG_DATA    = 8'hFF;

  localparam logic [7:0] NAME_CHARS [10] = '{
    8'h73, 8'h64, 8'h63, 8'h63, 8'h20, 8'h67, 8'h61, 8'h79, 8'h20, 8'h20
  };

  // positions of the variable bytes in the start sequence
  localparam logic [IdxW-1:0] POS_SIZE_LO = 5'd17;
  localparam logic [IdxW-1:0] POS_SIZE_HI = 5'd18;
  localparam logic [IdxW-1:0] POS_ADDR_LO = 5'd19;
  localparam logic [IdxW-1:0] POS_ADDR_HI = 5'd20;
  localparam logic [IdxW-1:0] POS_HDR_SUM = 5'd23;
  localparam logic [IdxW-1:0] POS_DLEN_LO = 5'd27;
  localparam logic [IdxW-1:0] POS_DLEN_HI = 5'd28;
  localparam logic [IdxW-1:0] POS_PFX_END = 5'd29;
  localparam logic [IdxW-1:0] POS_EMPTY_SUM = 5'd30;

  // XOR of the fixed header bytes covered by the header checksum
  function automatic logic [7:0] hdr_const_sum();
    logic [7:0] s;
    s = HDR_TYPE ^ HDR_PARAM_HI;
    for (int i = 0; i < 10; i++) begin
      s = s ^ NAME_CHARS[i];
    end
    return s;
  endfunction

  localparam logic [7:0] HDR_SUM_CONST = hdr_const_sum();

  // fixed bytes of the start sequence; variable positions return zero
  function automatic logic [7:0] start_byte(input logic [IdxW-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd0, 5'd24: b = BLOCK_ID;
      5'd1, 5'd25: b = PAUSE_LO;
      5'd2, 5'd26: b = PAUSE_HI;
      5'd3:        b = HDR_LEN_LO;
      5'd6:        b = HDR_TYPE;
      5'd7:        b = NAME_CHARS[0];
      5'd8:        b = NAME_CHARS[1];
      5'd9:        b = NAME_CHARS[2];
      5'd10:       b = NAME_CHARS[3];
      5'd11:       b = NAME_CHARS[4];
      5'd12:       b = NAME_CHARS[5];
      5'd13:       b = NAME_CHARS[6];
      5'd14:       b = NAME_CHARS[7];
      5'd15:       b = NAME_CHARS[8];
      5'd16:       b = NAME_CHARS[9];
      5'd22:       b = HDR_PARAM_HI;
      5'd29, 5'd30: b = FLAG_DATA;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* design/tape_code_block_framer_top.sv */
// Tape code block framer: top level.
// Uses tcbf_pkg for the fixed header bytes and register indexes.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action_i and code_byte_i.
//   action_i = 0 starts a frame and yields 30 bytes (header block plus data
//   prefix), or 31 when code_size is 0 (checksum 0xFF closes it at once).
//   action_i = 1 passes one code byte; the byte that completes code_size is
//   followed by the data checksum with frame_done_o set. A byte outside a
//   frame yields one result with status_o set and out_byte_o zero.
//   Output channel (out_valid_o / out_stall_i) gives one byte per transaction;
//   run_last_o marks the final byte of each input transaction.
//   The first result passes through the input register, then the output register.
//   The byte sequencer gives one result per cycle while the output register is free;
//   a code byte yields 1 result (2 when it closes the frame), a start 30 or 31.
//   The input register is freed in the cycle its last result moves to the
//   output register, so a new item is taken while results wait to be taken.
//   Stall on the output holds the output register and, once the sequencer
//   catches up, backs up into in_stall_o.
//   Reset clears the channels, closes any frame, sets code_size to 0 and
//   load_address to 0x8000. Write config only while the block is idle.
`default_nettype none

module tape_code_block_framer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  code_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  out_byte_o,
  output      logic        run_last_o,
  output      logic        frame_done_o,
  output      logic        status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [tcbf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [15:0] code_size_q;
  logic [15:0] load_addr_q;
  logic [7:0]  run_xor_q, run_xor_d;
  logic [15:0] seen_q, seen_d;
  logic        in_frame_q, in_frame_d;

  logic        in_valid_q;
  logic        in_action_q;
  logic [7:0]  in_byte_q;
  logic [tcbf_pkg::IdxW-1:0] idx_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q, res_byte;
  logic        out_last_q, res_last;
  logic        out_done_q, res_done;
  logic        out_status_q, res_status;

  logic        out_free, emit, consume, in_load;
  logic        size_zero, closes;
  logic [15:0] seen_inc, dlen;
  logic [7:0]  hdr_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = in_valid_q && out_free;
  assign consume    = emit && res_last;
  assign in_stall_o = in_valid_q && !consume;
  assign in_load    = in_valid_i && !in_stall_o;

  assign size_zero = (code_size_q == 16'd0);
  assign seen_inc  = seen_q + 16'd1;
  assign closes    = (seen_inc >= code_size_q);
  assign dlen      = code_size_q + 16'd2;
  assign hdr_sum   = tcbf_pkg::HDR_SUM_CONST ^ code_size_q[7:0] ^ code_size_q[15:8]
                   ^ load_addr_q[7:0] ^ load_addr_q[15:8];

  // result for the current position of the item in the input register
  always_comb begin
    res_byte   = 8'h00;
    res_last   = 1'b0;
    res_done   = 1'b0;
    res_status = 1'b0;
    run_xor_d  = run_xor_q;
    seen_d     = seen_q;
    in_frame_d = in_frame_q;
    if (!in_action_q) begin
      case (idx_q)
        tcbf_pkg::POS_SIZE_LO: res_byte = code_size_q[7:0];
        tcbf_pkg::POS_SIZE_HI: res_byte = code_size_q[15:8];
        tcbf_pkg::POS_ADDR_LO: res_byte = load_addr_q[7:0];
        tcbf_pkg::POS_ADDR_HI: res_byte = load_addr_q[15:8];
        tcbf_pkg::POS_HDR_SUM: res_byte = hdr_sum;
        tcbf_pkg::POS_DLEN_LO: res_byte = dlen[7:0];
        tcbf_pkg::POS_DLEN_HI: res_byte = dlen[15:8];
        default:               res_byte = tcbf_pkg::start_byte(idx_q);
      endcase
      res_last   = size_zero ? (idx_q == tcbf_pkg::POS_EMPTY_SUM)
                             : (idx_q == tcbf_pkg::POS_PFX_END);
      res_done   = (idx_q == tcbf_pkg::POS_EMPTY_SUM);
      run_xor_d  = tcbf_pkg::FLAG_DATA;
      seen_d     = 16'd0;
      in_frame_d = !size_zero;
    end else if (!in_frame_q) begin
      res_last   = 1'b1;
      res_status = 1'b1;
    end else begin
      if (idx_q == '0) begin
        res_byte = in_byte_q;
        res_last = !closes;
      end else begin
        res_byte = run_xor_q ^ in_byte_q;
        res_last = 1'b1;
        res_done = 1'b1;
      end
      run_xor_d  = run_xor_q ^ in_byte_q;
      seen_d     = seen_inc;
      in_frame_d = !closes;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_size_q <= 16'd0;
      load_addr_q <= tcbf_pkg::LOAD_ADDR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcbf_pkg::CFG_CODE_SIZE: code_size_q <= cfg_wdata_i;
        tcbf_pkg::CFG_LOAD_ADDR: load_addr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // frame state and sequencer position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_xor_q  <= tcbf_pkg::FLAG_DATA;
      seen_q     <= 16'd0;
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      in_valid_q <= 1'b0;
    end else begin
      if (consume) begin
        run_xor_q  <= run_xor_d;
        seen_q     <= seen_d;
        in_frame_q <= in_frame_d;
        idx_q      <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
      end
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_action_q <= action_i;
      in_byte_q   <= code_byte_i;
    end
  end

  // output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= res_byte;
      out_last_q   <= res_last;
      out_done_q   <= res_done;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = out_last_q;
  assign frame_done_o = out_done_q;
  assign status_o     = out_status_q;

endmodule

`default_nettype wire

/* design/tcbf_checker.sv */
// Port-level checks for the tape code block framer.
// Bound to tape_code_block_framer_top; uses only its ports.
`default_nettype none

module tcbf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o,
  input wire logic       frame_done_o,
  input wire logic       status_o
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(frame_done_o) && $stable(status_o))
    else $error("stalled result changed");

  // the closing checksum ends its transaction group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> run_last_o && !status_o)
    else $error("frame_done without run_last");

  // a dropped byte reports alone, with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> run_last_o && !frame_done_o && (out_byte_o == 8'h00))
    else $error("bad status result");

  // after a closing checksum is taken, the next result cannot be another checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_done_o ##1 out_valid_o |-> !frame_done_o)
    else $error("back-to-back frame_done");

endmodule

bind tape_code_block_framer_top tcbf_checker u_tcbf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .run_last_o   (run_last_o),
  .frame_done_o (frame_done_o),
  .status_o     (status_o)
);

`default_nettype wire
